FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/crc8h_pkg.sv
// ----------------------------------------------------------------------------
// CRC-8 hex frame checker package
// Shared types, constants and CRC/hex helper functions.
// ----------------------------------------------------------------------------
package crc8h_pkg;

    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] CRC_INIT   = 8'h00;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [3:0] NIB_TEN    = 4'd10;

    localparam logic OP_CHECK    = 1'b0;
    localparam logic OP_GENERATE = 1'b1;

    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic       too_short;
        logic [7:0] low_char;
        logic [7:0] high_char;
        logic [7:0] crc_value;
        logic       crc_ok;
    } result_t;

    // Bitwise CRC-8 update, MSB first, no reflection.
    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (v[7])
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            else
                v = {v[6:0], 1'b0};
        end
        return v;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < NIB_TEN)
            c = CHAR_ZERO + {4'h0, nib};
        else
            c = CHAR_A + {4'h0, nib - NIB_TEN};
        return c;
    endfunction

endpackage

FILE: sv/crc8_ascii_hex_frame_checker.sv
// ----------------------------------------------------------------------------
// CRC-8 ASCII hex frame checker
// Checks or generates a two-character hex CRC-8 trailer on a byte stream.
// ----------------------------------------------------------------------------
// The block takes one message byte per cycle and keeps taking bytes back to
// back; each byte is held in the input register while the CRC-8 (polynomial
// 0x07, initial value 0) and the two-byte trailer delay are updated. The
// result is registered in the output register when the final byte leaves
// the input register, and a result waiting there stalls only a following
// final byte until it is taken. The last two bytes of every message are the
// trailer. In check mode crc_ok tells whether they equal the expected upper
// case hex characters; in generate mode crc_ok is 1. A message of one byte
// gives too_short = 1 and crc_ok = 0.
module crc8_ascii_hex_frame_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [0] crc_ok, [8:1] crc_value, [16:9] high_char,
                                   // [24:17] low_char, [25] too_short, [31:26] zero
);
    import crc8h_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    result_t   out_res_reg;
    result_t   result;
    logic      advance;

    // A byte without a result always moves on; a final byte needs the output slot.
    assign advance  = in_valid_reg && (!in_item_reg.last || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    crc8h_engine u_engine
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance && in_item_reg.last)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_item_reg <= '{op: s_tuser, data: s_tdata, last: s_tlast};
        if (advance && in_item_reg.last)
            out_res_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, out_res_reg};

endmodule

FILE: sv/crc8h_engine.sv
// ----------------------------------------------------------------------------
// CRC-8 hex frame engine
// Holds the two-byte trailer delay and the running CRC, and forms the result.
// ----------------------------------------------------------------------------
module crc8h_engine
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  crc8h_pkg::in_item_t item,
    output crc8h_pkg::result_t  result
);
    import crc8h_pkg::*;

    logic [7:0] acc_reg, acc_next;
    logic [7:0] h0_reg, h0_next;
    logic [7:0] h1_reg, h1_next;
    logic [1:0] cnt_reg, cnt_next;

    logic [7:0] upd_acc, upd_h0, upd_h1;
    logic [1:0] upd_cnt;
    logic [7:0] hc, lc;
    logic       short_msg;

    // State after taking the current byte, before the end-of-message clear.
    always_comb
    begin
        upd_acc = acc_reg;
        upd_h0  = h0_reg;
        upd_h1  = h1_reg;
        upd_cnt = cnt_reg;
        if (cnt_reg[1])
        begin
            // The older held byte leaves the delay and is payload.
            upd_acc = crc8_fold(acc_reg, h0_reg);
            upd_h0  = h1_reg;
            upd_h1  = item.data;
            upd_cnt = 2'd2;
        end
        else
        begin
            if (cnt_reg[0])
                upd_h1 = item.data;
            else
                upd_h0 = item.data;
            upd_cnt = cnt_reg + 2'd1;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        h0_next  = h0_reg;
        h1_next  = h1_reg;
        cnt_next = cnt_reg;
        if (advance)
        begin
            h0_next = upd_h0;
            h1_next = upd_h1;
            if (item.last)
            begin
                acc_next = CRC_INIT;
                cnt_next = 2'd0;
            end
            else
            begin
                acc_next = upd_acc;
                cnt_next = upd_cnt;
            end
        end
    end

    always_comb
    begin
        hc        = hex_char(upd_acc[7:4]);
        lc        = hex_char(upd_acc[3:0]);
        short_msg = ~upd_cnt[1];
        result.crc_value = upd_acc;
        result.high_char = hc;
        result.low_char  = lc;
        result.too_short = short_msg;
        if (short_msg)
            result.crc_ok = 1'b0;
        else if (item.op == OP_GENERATE)
            result.crc_ok = 1'b1;
        else
            result.crc_ok = (upd_h0 == hc) && (upd_h1 == lc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= CRC_INIT;
            cnt_reg <= 2'd0;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h0_reg <= h0_next;
        h1_reg <= h1_next;
    end

endmodule

FILE: sv/crc8h_checker.sv
// ----------------------------------------------------------------------------
// CRC-8 hex frame checker assertions
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crc8h_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A stalled result must hold.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // A short message reports failure and the CRC of an empty payload.
    `ASSERT_IMPL(a_short, clk, rst_n, m_tvalid && m_tdata[25], !m_tdata[0] && (m_tdata[8:1] == 8'h00), "short message result wrong")

    // The hex characters follow from the reported CRC.
    `ASSERT_IMPL(a_high_char, clk, rst_n, m_tvalid, m_tdata[16:9] == ((m_tdata[8:5] < 4'd10) ? (8'h30 + {4'h0, m_tdata[8:5]}) : (8'h37 + {4'h0, m_tdata[8:5]})), "upper hex character wrong")

    `ASSERT_IMPL(a_low_char, clk, rst_n, m_tvalid, m_tdata[24:17] == ((m_tdata[4:1] < 4'd10) ? (8'h30 + {4'h0, m_tdata[4:1]}) : (8'h37 + {4'h0, m_tdata[4:1]})), "lower hex character wrong")

endmodule

bind crc8_ascii_hex_frame_checker crc8h_checker u_crc8h_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-8 ASCII hex frame checker testbench
// Streams short messages with hex CRC trailers into the checker, predicts each
// result with an independent CRC-8 and trailer model, and compares every
// result request against the oldest predicted one.
// ----------------------------------------------------------------------------
module testbench;

    import crc8h_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int TARGET_ITEMS = 1300;
    localparam int IDLE_PCT     = 9;
    localparam int QUIET_START  = 600;
    localparam int QUIET_END    = 1100;
    localparam int HOLD_START   = 300;
    localparam int HOLD_LEN     = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    in_item_t    byte_queue[$];
    result_t     expected_results[$];
    logic [7:0]  msg[$];

    // Predictor state: running CRC and the two-byte trailer delay.
    logic [7:0]  crc_acc;
    logic [7:0]  held_bytes [2];
    logic [1:0]  held_count;

    int          cycle_count    = 0;
    int          mismatch_count = 0;
    int          stall_cycles   = 0;
    int          hold_cnt;

    crc8_ascii_hex_frame_checker u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            v = v[7] ? ({v[6:0], 1'b0} ^ 8'h07) : {v[6:0], 1'b0};
        end
        return v;
    endfunction

    function automatic logic [7:0] to_hex(input logic [3:0] nib);
        return (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h41 + {4'h0, nib - 4'd10});
    endfunction

    function automatic bit quiet_window();
        return cycle_count >= QUIET_START && cycle_count < QUIET_END;
    endfunction

    task automatic reset_prediction();
        crc_acc       = 8'h00;
        held_bytes[0] = 8'h00;
        held_bytes[1] = 8'h00;
        held_count    = 2'd0;
    endtask

    // Advance the predictor by one accepted byte; a final byte yields a result.
    task automatic predict_frame_byte(input in_item_t it);
        result_t r;
        if (held_count >= 2'd2)
        begin
            crc_acc       = crc8_step(crc_acc, held_bytes[0]);
            held_bytes[0] = held_bytes[1];
            held_bytes[1] = it.data;
            held_count    = 2'd2;
        end
        else
        begin
            held_bytes[held_count[0]] = it.data;
            held_count = held_count + 2'd1;
        end
        if (it.last)
        begin
            r.crc_value = crc_acc;
            r.high_char = to_hex(crc_acc[7:4]);
            r.low_char  = to_hex(crc_acc[3:0]);
            r.too_short = (held_count < 2'd2);
            if (r.too_short)
                r.crc_ok = 1'b0;
            else if (it.op == OP_GENERATE)
                r.crc_ok = 1'b1;
            else
                r.crc_ok = (held_bytes[0] == r.high_char) && (held_bytes[1] == r.low_char);
            expected_results.push_back(r);
            reset_prediction();
        end
    endtask

    // Append the correct trailer for the payload in msg, optionally damaged.
    task automatic add_trailer(input bit corrupt);
        logic [7:0] crc;
        int         pos;
        crc = 8'h00;
        foreach (msg[i])
            crc = crc8_step(crc, msg[i]);
        msg.push_back(to_hex(crc[7:4]));
        msg.push_back(to_hex(crc[3:0]));
        if (corrupt)
        begin
            pos = msg.size() - 1 - $urandom_range(0, 1);
            if ($urandom_range(0, 1) == 0)
                msg[pos] = msg[pos] | 8'h20;
            else
                msg[pos] = msg[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
    endtask

    // Queue msg as one message; operation on earlier bytes is noise.
    task automatic send_msg(input logic final_op);
        in_item_t it;
        foreach (msg[i])
        begin
            it.data = msg[i];
            it.last = (i == msg.size() - 1);
            it.op   = it.last ? final_op : logic'($urandom_range(0, 1));
            byte_queue.push_back(it);
        end
        msg.delete();
    endtask

    task automatic random_payload(input int len);
        for (int i = 0; i < len; i++)
            msg.push_back(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int r;
        reset_prediction();

        // Short messages in both modes.
        msg = '{8'h00};
        send_msg(OP_CHECK);
        msg = '{8'hFF};
        send_msg(OP_GENERATE);
        // Empty payload: the trailer of the empty CRC is "00".
        msg = '{8'h30, 8'h30};
        send_msg(OP_CHECK);
        msg = '{8'h30, 8'h31};
        send_msg(OP_CHECK);
        msg = '{8'hFF, 8'h00};
        send_msg(OP_GENERATE);
        // Extreme payload bytes with good and bad trailers.
        msg = '{8'hFF};
        add_trailer(1'b0);
        send_msg(OP_CHECK);
        msg = '{8'h00};
        add_trailer(1'b0);
        send_msg(OP_CHECK);
        msg = '{8'h80, 8'h01};
        add_trailer(1'b1);
        send_msg(OP_CHECK);
        msg = '{8'hA5, 8'h5A, 8'hFF};
        add_trailer(1'b0);
        send_msg(OP_GENERATE);
        // A lowercase trailer never matches.
        msg = '{8'h12, 8'h34};
        add_trailer(1'b0);
        msg[msg.size()-1] = msg[msg.size()-1] | 8'h20;
        msg[msg.size()-2] = msg[msg.size()-2] | 8'h20;
        send_msg(OP_CHECK);

        while (byte_queue.size() < TARGET_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
            begin
                random_payload(1);
                send_msg(logic'($urandom_range(0, 1)));
            end
            else if (r < 14)
            begin
                random_payload($urandom_range(2, 10));
                send_msg(logic'($urandom_range(0, 1)));
            end
            else
            begin
                random_payload($urandom_range(0, 10));
                add_trailer($urandom_range(0, 99) < 15);
                send_msg(($urandom_range(0, 99) < 70) ? OP_CHECK : OP_GENERATE);
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_queue.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Driver: predicts on acceptance, then offers the next pending byte.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_frame_byte('{op: s_tuser, data: s_tdata, last: s_tlast});
            if (!s_tvalid || s_tready)
            begin
                if (byte_queue.size() != 0
                    && (quiet_window() || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    in_item_t it;
                    it = byte_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= it.data;
                    s_tlast  <= it.last;
                    s_tuser  <= it.op;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result request; holds off once for a long stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_cnt <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                result_t got;
                result_t exp;
                got = result_t'(m_tdata[25:0]);
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result: tdata=%h", m_tdata);
                end
                else
                begin
                    exp = expected_results.pop_front();
                    if (got !== exp || m_tdata[31:26] !== 6'd0)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("result mismatch: expected tdata=%h, got tdata=%h",
                                     {6'd0, exp}, m_tdata);
                    end
                end
            end
            if (cycle_count == HOLD_START)
            begin
                hold_cnt <= HOLD_LEN;
                m_tready <= 1'b0;
            end
            else if (hold_cnt > 0)
            begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= quiet_window() || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog on cycles in which neither side moves a request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule

FILE: sim.f
+incdir+sv
sv/crc8h_pkg.sv
sv/crc8h_engine.sv
sv/crc8_ascii_hex_frame_checker.sv
sv/crc8h_checker.sv
dv/testbench.sv
